// ----- hw/rtl/lfs_pkg.sv -----
// Shared types and constants for the LED strip frame streamer.
// Used by lfs_ctrl, lfs_datapath and led_strip_frame_streamer; depends on nothing.
`default_nettype none

package lfs_pkg;

  localparam int LED_COUNT   = 8;
  localparam int END_BYTES   = 4;
  localparam int START_BYTES = 4;
  localparam int FRAME_LEN   = START_BYTES + 4 * LED_COUNT + END_BYTES;
  localparam int POS_W       = $clog2(FRAME_LEN + 1);
  localparam int LED_W       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [LED_W-1:0] led_idx_t;

  localparam pos_t POS_START_END = pos_t'(START_BYTES);
  localparam pos_t POS_PIX_LEN   = pos_t'(4 * LED_COUNT);
  localparam pos_t POS_IDLE      = pos_t'(FRAME_LEN);

  localparam logic [7:0] BYTE_ON  = 8'hFF;
  localparam logic [7:0] BYTE_OFF = 8'h00;

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_START = 2'd1,
    REQ_TICK  = 2'd2
  } req_t;

  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic do_set;
    logic do_start;
    logic do_tick;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lfs_ctrl.sv -----
// Controller for the LED strip frame streamer: handshake state and request decode.
// Depends on lfs_pkg; drives the command struct into lfs_datapath.
`default_nettype none

module lfs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [1:0]    req_type,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output lfs_pkg::cmd_t      cmd
);

  lfs_pkg::state_t state, state_next;
  logic            accept;

  assign s_tready = (state == lfs_pkg::ST_EMPTY) || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfs_pkg::ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lfs_pkg::ST_EMPTY: begin
        if (accept) state_next = lfs_pkg::ST_FULL;
      end
      lfs_pkg::ST_FULL: begin
        if (accept) state_next = lfs_pkg::ST_FULL;
        else if (m_tready) state_next = lfs_pkg::ST_EMPTY;
      end
      default: state_next = lfs_pkg::ST_EMPTY;
    endcase
  end

  always_comb begin
    m_tvalid     = (state == lfs_pkg::ST_FULL);
    cmd.load     = accept;
    cmd.do_set   = 1'b0;
    cmd.do_start = 1'b0;
    cmd.do_tick  = 1'b0;
    case (req_type)
      lfs_pkg::REQ_SET:   cmd.do_set   = accept;
      lfs_pkg::REQ_START: cmd.do_start = accept;
      lfs_pkg::REQ_TICK:  cmd.do_tick  = accept;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lfs_datapath.sv -----
// Datapath for the LED strip frame streamer: colour registers, send position,
// frame byte select and result register. Depends on lfs_pkg.
`default_nettype none

module lfs_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lfs_pkg::cmd_t cmd,
  input  wire logic [7:0]    led_index,
  input  wire logic [7:0]    red,
  input  wire logic [7:0]    green,
  input  wire logic [7:0]    blue,
  output logic               byte_valid,
  output logic [7:0]         tx_byte,
  output logic               finished
);

  logic [23:0]       colours [lfs_pkg::LED_COUNT];
  lfs_pkg::pos_t     pos;
  lfs_pkg::pos_t     q;
  lfs_pkg::led_idx_t led;
  logic [23:0]       colour;
  logic [7:0]        frame_byte;
  logic              in_range;
  logic              sending;

  assign in_range = {1'b0, led_index} < 9'(lfs_pkg::LED_COUNT);
  assign sending  = pos < lfs_pkg::POS_IDLE;
  assign q        = pos - lfs_pkg::POS_START_END;
  assign led      = lfs_pkg::led_idx_t'(q >> 2);
  assign colour   = colours[led];

  always_comb begin
    if (pos < lfs_pkg::POS_START_END) begin
      frame_byte = lfs_pkg::BYTE_OFF;
    end else if (q >= lfs_pkg::POS_PIX_LEN) begin
      frame_byte = lfs_pkg::BYTE_ON;
    end else begin
      case (q[1:0])
        2'd0:    frame_byte = lfs_pkg::BYTE_ON;
        2'd1:    frame_byte = colour[7:0];
        2'd2:    frame_byte = colour[15:8];
        default: frame_byte = colour[23:16];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lfs_pkg::LED_COUNT; i++) colours[lfs_pkg::led_idx_t'(i)] <= 24'd0;
    end else if (cmd.do_set && in_range) begin
      colours[lfs_pkg::led_idx_t'(led_index)] <= {red, green, blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= lfs_pkg::POS_IDLE;
    end else if (cmd.do_start) begin
      pos <= '0;
    end else if (cmd.do_tick && sending) begin
      pos <= pos + 1'b1;
    end
  end

  // hold the result until the next accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_valid <= cmd.do_tick && sending;
      tx_byte    <= (cmd.do_tick && sending) ? frame_byte : 8'd0;
      finished   <= cmd.do_tick && !sending;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/led_strip_frame_streamer.sv -----
// LED strip frame streamer: one 8-entry RGB store and a byte-per-tick frame sender.
// The colour store is eight 24-bit registers, so a tick reads its colour in the same
// cycle. Every beat in gives exactly one beat out, in the cycle after it is taken. A new
// beat is taken in the cycle the held result is taken, so the block sustains one beat per
// cycle while the output is not stalled; the single result register is the only
// buffering. Depends on lfs_pkg, lfs_ctrl and lfs_datapath.
`default_nettype none

module led_strip_frame_streamer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // led_index, red, green, blue
  input  wire logic [1:0]  s_tuser,  // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // tx_byte
  output logic [1:0]       m_tuser   // byte_valid, finished
);

  lfs_pkg::cmd_t cmd;
  logic          byte_valid;
  logic          finished;

  lfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lfs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .led_index  (s_tdata[7:0]),
    .red        (s_tdata[15:8]),
    .green      (s_tdata[23:16]),
    .blue       (s_tdata[31:24]),
    .byte_valid (byte_valid),
    .tx_byte    (m_tdata),
    .finished   (finished)
  );

  assign m_tuser = {finished, byte_valid};

`ifndef ASSERT_OFF
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("byte_valid and finished both set");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
    else $error("tx_byte nonzero without byte_valid");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted beat produced no result");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for led_strip_frame_streamer: drives pixel, start and tick beats,
// predicts every result beat, and checks each one as it comes out under random stalls.
// Depends on lfs_pkg and the RTL of led_strip_frame_streamer.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] REQ_SPARE   = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         ITEM_GOAL   = 1850;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } strip_req_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] tx_byte;
    logic       finished;
  } strip_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // led_index, red, green, blue
  logic [1:0]  s_tuser = '0;   // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // tx_byte
  logic [1:0]  m_tuser;        // byte_valid, finished

  led_strip_frame_streamer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  strip_req_t  reqs_pending [$];
  strip_beat_t beats_due [$];
  strip_req_t  on_bus;
  logic [23:0] shade [lfs_pkg::LED_COUNT];
  int unsigned cursor;
  int          n_in, n_out, n_planned, n_sent_bytes, n_frames_done, errors, stall;
  int          n_queued;
  logic        steady;

  assign steady = (n_in >= 700) && (n_in < 1100);

  // Model of the block: update the colour store and send position, return the result beat.
  function automatic strip_beat_t strip_respond(strip_req_t q);
    strip_beat_t o;
    int unsigned rel;
    o = '0;
    case (q.kind)
      lfs_pkg::REQ_SET: begin
        if (q.idx < lfs_pkg::LED_COUNT)
          shade[lfs_pkg::led_idx_t'(q.idx)] = {q.red, q.green, q.blue};
      end
      lfs_pkg::REQ_START: cursor = 0;
      lfs_pkg::REQ_TICK: begin
        if (cursor < lfs_pkg::FRAME_LEN) begin
          o.byte_valid = 1'b1;
          if (cursor < lfs_pkg::START_BYTES) begin
            o.tx_byte = lfs_pkg::BYTE_OFF;
          end else begin
            rel = cursor - lfs_pkg::START_BYTES;
            if (rel >= 4 * lfs_pkg::LED_COUNT) begin
              o.tx_byte = lfs_pkg::BYTE_ON;
            end else begin
              case (rel % 4)
                0: o.tx_byte = lfs_pkg::BYTE_ON;
                1: o.tx_byte = shade[rel / 4][7:0];
                2: o.tx_byte = shade[rel / 4][15:8];
                default: o.tx_byte = shade[rel / 4][23:16];
              endcase
            end
          end
          cursor++;
        end else begin
          cursor = lfs_pkg::FRAME_LEN;
          o.finished = 1'b1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic queue_req(input logic [1:0] kind, input logic [7:0] idx,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    strip_req_t q;
    q = '{kind, idx, r, g, b};
    reqs_pending.push_back(q);
    if (!(kind == REQ_SPARE || (kind == lfs_pkg::REQ_SET && idx >= lfs_pkg::LED_COUNT)))
      n_planned++;
  endtask

  // Driver: predict on acceptance, then present the next beat or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        beats_due.push_back(strip_respond(on_bus));
        n_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (reqs_pending.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
          on_bus = reqs_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {on_bus.blue, on_bus.green, on_bus.red, on_bus.idx};
          s_tuser <= on_bus.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    strip_beat_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_out++;
        if (beats_due.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing pending", n_out));
        end else begin
          want = beats_due.pop_front();
          if (m_tdata !== want.tx_byte)
            report_mismatch($sformatf("beat %0d tx_byte %h, want %h", n_out, m_tdata,
                                      want.tx_byte));
          if (m_tuser[0] !== want.byte_valid)
            report_mismatch($sformatf("beat %0d byte_valid %b, want %b", n_out, m_tuser[0],
                                      want.byte_valid));
          if (m_tuser[1] !== want.finished)
            report_mismatch($sformatf("beat %0d finished %b, want %b", n_out, m_tuser[1],
                                      want.finished));
          if (want.byte_valid) n_sent_bytes++;
          if (want.finished) n_frames_done++;
        end
      end
      m_tready <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int tail, k;
    for (int i = 0; i < lfs_pkg::LED_COUNT; i++) shade[i] = '0;
    cursor = lfs_pkg::FRAME_LEN;
    n_in = 0; n_out = 0; n_planned = 0; n_sent_bytes = 0; n_frames_done = 0;
    errors = 0; stall = 0; n_queued = 0;

    // Directed: idle tick, colour extremes, bad indexes, spare code, a partial frame.
    queue_req(lfs_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_req(lfs_pkg::REQ_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    queue_req(lfs_pkg::REQ_SET, 8'(lfs_pkg::LED_COUNT - 1), 8'hFF, 8'h00, 8'h55);
    queue_req(lfs_pkg::REQ_SET, 8'(lfs_pkg::LED_COUNT), 8'h12, 8'h34, 8'h56);
    queue_req(lfs_pkg::REQ_SET, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_req(REQ_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_req(lfs_pkg::REQ_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    repeat (14) queue_req(lfs_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_req(lfs_pkg::REQ_SET, 8'd3, 8'hA5, 8'h5A, 8'hC3);
    queue_req(lfs_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_req(lfs_pkg::REQ_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    // Random: mostly whole frames with colour updates mixed in, some loose noise.
    while (n_planned < ITEM_GOAL) begin
      if ($urandom_range(0, 99) < 80) begin
        repeat ($urandom_range(0, 4))
          queue_req(lfs_pkg::REQ_SET,
                    ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, lfs_pkg::LED_COUNT - 1)),
                    8'($urandom), 8'($urandom), 8'($urandom));
        queue_req(lfs_pkg::REQ_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        tail = lfs_pkg::FRAME_LEN + $urandom_range(1, 3);
        for (k = 0; k < tail; k++) begin
          if ($urandom_range(0, 9) == 0)
            queue_req(lfs_pkg::REQ_SET, 8'($urandom_range(0, lfs_pkg::LED_COUNT - 1)),
                      8'($urandom), 8'($urandom), 8'($urandom));
          if ($urandom_range(0, 99) == 0)
            queue_req(lfs_pkg::REQ_START, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
          queue_req(lfs_pkg::REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          queue_req(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
      end
    end
    n_queued = reqs_pending.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (n_out < n_queued) @(posedge clk);
    repeat (8) @(posedge clk);
    if (beats_due.size() != 0 || n_in != n_out)
      report_mismatch($sformatf("%0d beats in, %0d beats out", n_in, n_out));

    $display("Sent %0d request beats, checked %0d result beats (%0d frame bytes,",
             n_in, n_out, n_sent_bytes);
    $display("  %0d end-of-frame reports), %0d mismatches", n_frames_done, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lfs_pkg.sv
hw/rtl/lfs_ctrl.sv
hw/rtl/lfs_datapath.sv
hw/rtl/led_strip_frame_streamer.sv
sim/testbench.sv
